>>> rtl/assert_macros.svh
// Assertion helpers included by differential_drive_pi_speed_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication or plain property, checked on every rising edge out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Expression that must never be true out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> rtl/ddps_pkg.sv
`timescale 1ns / 1ps

package ddps_pkg;

  localparam int IN_W      = 16;   // input field width
  localparam int TGT_W     = 17;   // wheel target width
  localparam int ERR_W     = 18;   // error and filtered error width
  localparam int INT_W     = 16;   // integral width
  localparam int GAIN_W    = 16;   // Q8.8 gain width
  localparam int PROD_W    = 35;   // widest product width
  localparam int LOUT_W    = 17;   // clamped lane output width
  localparam int DUTY_W    = 10;   // duty field width
  localparam int FRAC_BITS = 8;    // Q8.8 fraction bits

  localparam int OUTPUT_LIMIT   = 1000;
  localparam int INTEGRAL_LIMIT = 20000;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = CFG_IDX_W'(1);

  // Stage load strobes from the top level control to the lanes and merge
  typedef struct packed {
    logic load_s1;
    logic load_s2;
    logic load_out;
  } ddps_ctrl_t;

endpackage

>>> rtl/ddps_lane.sv
`timescale 1ns / 1ps

module ddps_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ddps_pkg::ddps_ctrl_t                  ctrl,
  input  logic        [ddps_pkg::GAIN_W-1:0]    gain_p,
  input  logic        [ddps_pkg::GAIN_W-1:0]    gain_i,
  input  logic signed [ddps_pkg::TGT_W-1:0]     target,
  input  logic signed [ddps_pkg::IN_W-1:0]      measured,
  output logic signed [ddps_pkg::LOUT_W-1:0]    lane_out
);
  import ddps_pkg::*;

  localparam int SUM_W = ERR_W + 1;
  localparam int ACC_W = PROD_W + 1;
  localparam int Q_W   = ACC_W - FRAC_BITS;

  localparam logic signed [SUM_W-1:0] INT_HI = SUM_W'(INTEGRAL_LIMIT);
  localparam logic signed [SUM_W-1:0] INT_LO = SUM_W'(-INTEGRAL_LIMIT);
  localparam logic signed [Q_W-1:0]   OUT_HI = Q_W'(OUTPUT_LIMIT);
  localparam logic signed [Q_W-1:0]   OUT_LO = Q_W'(-OUTPUT_LIMIT);
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'((1 << FRAC_BITS) - 1);

  // Loop state
  logic signed [ERR_W-1:0]  filt_r, filt_nxt;
  logic signed [INT_W-1:0]  integ_r, integ_nxt;

  // Pipeline registers
  logic signed [ERR_W-1:0]  s1_filt_r;
  logic signed [INT_W-1:0]  s1_integ_r;
  logic signed [PROD_W-1:0] s2_prod_p_r, s2_prod_i_r;

  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W-1:0]  avg_sum, avg_adj, int_sum;
  logic signed [ACC_W-1:0]  acc, acc_adj;
  logic signed [Q_W-1:0]    quot;

  // Filter and integral update, the only loop-carried path
  always_comb begin
    err       = ERR_W'(target) - ERR_W'(measured);
    avg_sum   = SUM_W'(err) + SUM_W'(filt_r);
    avg_adj   = avg_sum + SUM_W'(avg_sum[SUM_W-1]);
    filt_nxt  = avg_adj[SUM_W-1:1];
    int_sum   = SUM_W'(integ_r) + SUM_W'(filt_nxt);
    if (int_sum > INT_HI) begin
      integ_nxt = INT_HI[INT_W-1:0];
    end else if (int_sum < INT_LO) begin
      integ_nxt = INT_LO[INT_W-1:0];
    end else begin
      integ_nxt = int_sum[INT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r  <= '0;
      integ_r <= '0;
    end else if (ctrl.load_s1) begin
      filt_r  <= filt_nxt;
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_s1) begin
      s1_filt_r  <= filt_nxt;
      s1_integ_r <= integ_nxt;
    end
    if (ctrl.load_s2) begin
      s2_prod_p_r <= PROD_W'($signed({1'b0, gain_p}) * s1_filt_r);
      s2_prod_i_r <= PROD_W'($signed({1'b0, gain_i}) * s1_integ_r);
    end
  end

  // Sum, scale toward zero, clamp
  always_comb begin
    acc     = ACC_W'(s2_prod_p_r) + ACC_W'(s2_prod_i_r);
    acc_adj = acc[ACC_W-1] ? (acc + RND) : acc;
    quot    = acc_adj[ACC_W-1:FRAC_BITS];
    if (quot > OUT_HI) begin
      lane_out = OUT_HI[LOUT_W-1:0];
    end else if (quot < OUT_LO) begin
      lane_out = OUT_LO[LOUT_W-1:0];
    end else begin
      lane_out = quot[LOUT_W-1:0];
    end
  end

endmodule

>>> rtl/ddps_merge.sv
`timescale 1ns / 1ps

module ddps_merge (
  input  logic                                   clk,
  input  ddps_pkg::ddps_ctrl_t                   ctrl,
  input  logic signed [ddps_pkg::LOUT_W-1:0]     left_out,
  input  logic signed [ddps_pkg::LOUT_W-1:0]     right_out,
  output logic        [ddps_pkg::OUT_TDATA_W-1:0] out_data
);
  import ddps_pkg::*;

  logic                    left_pos, right_pos;
  logic [LOUT_W-1:0]       left_mag, right_mag;
  logic [OUT_TDATA_W-1:0]  data_r, data_nxt;

  // Zero counts as not positive on both sides
  always_comb begin
    left_pos  = !left_out[LOUT_W-1] && (left_out != '0);
    right_pos = !right_out[LOUT_W-1] && (right_out != '0);
    left_mag  = left_out[LOUT_W-1] ? LOUT_W'(-left_out) : LOUT_W'(left_out);
    right_mag = right_out[LOUT_W-1] ? LOUT_W'(-right_out) : LOUT_W'(right_out);
    data_nxt  = {!right_pos, right_pos, right_mag[DUTY_W-1:0],
                 left_pos, !left_pos, left_mag[DUTY_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      data_r <= data_nxt;
    end
  end

  assign out_data = data_r;

endmodule

>>> rtl/differential_drive_pi_speed_core.sv
`timescale 1ns / 1ps
// An input transfer is registered in stage 1, stage 2 and the output register before out_tvalid.
// Throughput: one item per cycle while out_tready is high; both wheels run in their own lane.
// The per-wheel filter/integral update is the only loop; it closes through filt_r and integ_r.
// Reset (rst_n low, synchronous): gains, filtered errors and integrals go to
// zero, the pipeline empties; cfg_ready stays high.

module differential_drive_pi_speed_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Input channel
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // [15:0] fwd_cmd, [31:16] yaw_cmd, [47:32] left_count,
  // [63:48] right_count
  input  logic [ddps_pkg::IN_TDATA_W-1:0]         in_tdata,
  // Result channel
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // [9:0] left_duty, [10] left_pin_one, [11] left_pin_two,
  // [21:12] right_duty, [22] right_pin_one, [23] right_pin_two
  output logic [ddps_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // Configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ddps_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ddps_pkg::GAIN_W-1:0]             cfg_data
);
  import ddps_pkg::*;

`include "assert_macros.svh"

  logic [GAIN_W-1:0] gain_p_r, gain_i_r;
  logic              s1_v_r, s1_v_nxt;
  logic              s2_v_r, s2_v_nxt;
  logic              out_v_r, out_v_nxt;
  logic              out_free, s2_free, s1_free;
  ddps_ctrl_t        ctrl;

  logic signed [IN_W-1:0]   fwd, turn, lcnt, rcnt;
  logic signed [TGT_W-1:0]  left_tgt, right_tgt;
  logic signed [LOUT_W-1:0] left_out, right_out;

  // Config writes land at once; gains must only be changed while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_P: gain_p_r <= cfg_data;
        REG_GAIN_I: gain_i_r <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Pipeline flow: each stage advances when the stage after it is empty or
  // moves on in the same cycle, so bubbles are squeezed out under stall.
  always_comb begin
    out_free      = !out_v_r || out_tready;
    ctrl.load_out = s2_v_r && out_free;
    s2_free       = !s2_v_r || ctrl.load_out;
    ctrl.load_s2  = s1_v_r && s2_free;
    s1_free       = !s1_v_r || ctrl.load_s2;
    in_tready     = s1_free;
    ctrl.load_s1  = in_tvalid && s1_free;

    s1_v_nxt  = ctrl.load_s1 ? 1'b1 : (ctrl.load_s2 ? 1'b0 : s1_v_r);
    s2_v_nxt  = ctrl.load_s2 ? 1'b1 : (ctrl.load_out ? 1'b0 : s2_v_r);
    out_v_nxt = ctrl.load_out ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_tvalid = out_v_r;

  // Unpack the transfer and form the wheel targets
  always_comb begin
    fwd       = in_tdata[IN_W-1:0];
    turn      = in_tdata[2*IN_W-1:IN_W];
    lcnt      = in_tdata[3*IN_W-1:2*IN_W];
    rcnt      = in_tdata[4*IN_W-1:3*IN_W];
    left_tgt  = TGT_W'(fwd) - TGT_W'(turn);
    right_tgt = TGT_W'(fwd) + TGT_W'(turn);
  end

  ddps_lane u_lane_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .gain_p   (gain_p_r),
    .gain_i   (gain_i_r),
    .target   (left_tgt),
    .measured (lcnt),
    .lane_out (left_out)
  );

  ddps_lane u_lane_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .gain_p   (gain_p_r),
    .gain_i   (gain_i_r),
    .target   (right_tgt),
    .measured (rcnt),
    .lane_out (right_out)
  );

  // Combine both wheels into the result word
  ddps_merge u_merge (
    .clk       (clk),
    .ctrl      (ctrl),
    .left_out  (left_out),
    .right_out (right_out),
    .out_data  (out_tdata)
  );

  // A blocked input always means the first stage holds an item
  `ASSERT_CLK(a_ready_stall, clk, rst_n, !in_tready |-> s1_v_r)
  // An accepted item occupies the front of the pipeline on the next cycle
  `ASSERT_CLK(a_flow_latency, clk, rst_n,
              (ctrl.load_s1 && out_tready && $past(out_tready)) |=> s2_v_r || s1_v_r)
  // Left direction pins are always complementary on a valid result
  `ASSERT_NEVER(a_left_pins, clk, rst_n, out_tvalid && (out_tdata[10] == out_tdata[11]))
  // Duty never exceeds the output limit
  `ASSERT_NEVER(a_duty_limit, clk, rst_n,
                out_tvalid && (out_tdata[9:0] > 10'(OUTPUT_LIMIT)))

endmodule
